// ===== hdl/pvba_pkg.sv =====
// ----------------------------------------------------------------------------
// pvba_pkg
// Types, constants and tables shared by the bin analysis block.
// ----------------------------------------------------------------------------
package pvba_pkg;

    localparam int WINDOW_SIZE  = 1024;  // power of two, 16 to 8192
    localparam int CORDIC_STEPS = 16;    // 8 to 24
    localparam int NUM_BINS     = 512;
    localparam int BIN_W        = 9;
    localparam int PHASE_W      = 16;
    localparam int HOP_W        = 11;
    localparam int GAIN_W       = 24;
    localparam int SAMPLE_W     = 24;
    localparam int MAG_W        = 24;
    localparam int FREQ_W       = 32;

    // CORDIC datapath: inputs scaled by 2^8, plus growth of the gain and diagonal
    localparam int XW      = SAMPLE_W + 8 + 4;
    localparam int ZW      = 32;
    localparam int MGAIN_W = 17;
    localparam logic signed [MGAIN_W-1:0] MAG_GAIN = 17'sd39797;
    localparam int MPW     = XW + MGAIN_W;

    // expected advance: bin * hop * 65536 / WINDOW_SIZE
    localparam int ADV_SHIFT = 16 - $clog2(WINDOW_SIZE);
    localparam int ADV_W     = BIN_W + HOP_W + ADV_SHIFT;
    localparam int TW        = ADV_W + 2;
    localparam int PW        = TW + GAIN_W + 1;

    localparam int PADDR_W = 3;
    localparam logic REG_HOP  = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    localparam logic [HOP_W-1:0]  HOP_RESET  = 11'd256;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd44100;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [ZW-1:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] real_part;
        logic signed [SAMPLE_W-1:0] imag_part;
        logic [BIN_W-1:0]           bin_index;
        logic                       first_frame;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]         bin_out;
        logic [MAG_W-1:0]         magnitude;
        logic signed [FREQ_W-1:0] frequency;
    } t_out_item;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             first;
        logic [BIN_W-1:0] bin;
    } t_tag;

endpackage

// ===== hdl/pvba_ram.sv =====
// ----------------------------------------------------------------------------
// pvba_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pvba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pvba_cordic.sv =====
// ----------------------------------------------------------------------------
// pvba_cordic
// Pipelined vectoring CORDIC: one input register, then one stage per step.
// ----------------------------------------------------------------------------
module pvba_cordic
    import pvba_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_tag                       i_tag,
    input  logic signed [SAMPLE_W-1:0] i_re,
    input  logic signed [SAMPLE_W-1:0] i_im,
    output t_tag                       o_tag,
    output logic signed [XW-1:0]       o_x,
    output logic [ZW-1:0]              o_z
);

    t_tag                r_tag [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_x  [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_y  [CORDIC_STEPS+1];
    logic [ZW-1:0]        r_z  [CORDIC_STEPS+1];

    t_tag                 n_tag0;
    logic signed [XW-1:0] n_x0, n_y0;
    logic [ZW-1:0]        n_z0;

    // turn a left half-plane vector by half a turn
    always_comb begin
        n_tag0      = i_tag;
        n_tag0.zero = (i_re == '0) && (i_im == '0);
        n_x0 = XW'($signed({i_re, 8'b0}));
        n_y0 = XW'($signed({i_im, 8'b0}));
        n_z0 = '0;
        if (i_re[SAMPLE_W-1]) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
            n_z0 = 32'h8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= n_tag0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [XW-1:0] dx, dy;
        logic                 up;

        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign up = !r_y[k][XW-1] && (r_y[k] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (up) begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + ATAN_TURNS[k];
                end else begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - ATAN_TURNS[k];
                end
            end
        end
    end

    assign o_tag = r_tag[CORDIC_STEPS];
    assign o_x   = r_x[CORDIC_STEPS];
    assign o_z   = r_z[CORDIC_STEPS];

endmodule

// ===== hdl/phase_vocoder_bin_analysis_top.sv =====
// ----------------------------------------------------------------------------
// phase_vocoder_bin_analysis_top
// Per-bin magnitude and instantaneous frequency for phase vocoder analysis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one spectrum bin
//   per transfer; output channel (o_out_valid / i_out_ready / o_out_item)
//   returns one result per bin, in input order.
//   Throughput: one bin per cycle while the output is not stalled. From the
//   input transfer to o_out_valid an item passes the input register, then
//   one stage per CORDIC step, the phase/memory stage, advance stage, gain
//   multiply stage and the output register.
//   The previous phase of each bin lives in a 512 x 16 RAM, read with the
//   bin index at the CORDIC output so that the data meets the stage that
//   writes back; a bypass covers back-to-back bins with the same index.
//   After reset the RAM is cleared one entry per cycle: o_in_ready stays low
//   until every entry is cleared. The APB port is usable throughout.
//   When the receiver stalls, the whole pipeline holds and o_in_ready drops
//   in the same cycle; nothing is lost or repeated.
//   Registers: hop_size at 0x0, freq_gain at 0x4.
// ----------------------------------------------------------------------------
module phase_vocoder_bin_analysis_top
    import pvba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration
    logic [HOP_W-1:0]  r_hop;
    logic [GAIN_W-1:0] r_gain;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop  <= HOP_RESET;
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HOP:  r_hop  <= pwdata[HOP_W-1:0];
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HOP:  prdata = {{(32-HOP_W){1'b0}}, r_hop};
            REG_GAIN: prdata = {{(32-GAIN_W){1'b0}}, r_gain};
            default:  prdata = '0;
        endcase
    end

    // clearing pass over the phase memory
    logic             r_clr_busy;
    logic [BIN_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == BIN_W'(NUM_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // global advance: hold everything while the output waits
    logic en;
    logic accept;
    logic r_out_valid;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en && !r_clr_busy;
    assign accept     = i_in_valid && o_in_ready;

    t_tag in_tag;
    t_tag c_tag;
    logic signed [XW-1:0] c_x;
    logic [ZW-1:0]        c_z;

    always_comb begin
        in_tag       = '0;
        in_tag.valid = accept;
        in_tag.first = i_in_item.first_frame;
        in_tag.bin   = i_in_item.bin_index;
    end

    pvba_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (in_tag),
        .i_re    (i_in_item.real_part),
        .i_im    (i_in_item.imag_part),
        .o_tag   (c_tag),
        .o_x     (c_x),
        .o_z     (c_z)
    );

    // stage A: phase, magnitude product, previous phase arrives from RAM
    t_tag                  r_a_tag;
    logic [PHASE_W-1:0]    r_a_phase;
    logic signed [MPW-1:0] r_a_magp;
    logic [ZW-1:0]         n_zr;

    assign n_zr = c_z + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else if (en) begin
            r_a_tag <= c_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_phase <= c_tag.zero ? '0 : n_zr[ZW-1:ZW-PHASE_W];
            r_a_magp  <= c_tag.zero ? '0 : c_x * MAG_GAIN;
        end
    end

    logic               ram_we;
    logic [BIN_W-1:0]   ram_waddr;
    logic [PHASE_W-1:0] ram_wdata;
    logic [BIN_W-1:0]   ram_raddr;
    logic [PHASE_W-1:0] ram_rdata;

    assign ram_we    = r_clr_busy || (en && r_a_tag.valid);
    assign ram_waddr = r_clr_busy ? r_clr_cnt : r_a_tag.bin;
    assign ram_wdata = r_clr_busy ? '0 : r_a_phase;
    // hold the read on the waiting item while stalled
    assign ram_raddr = en ? c_tag.bin : r_a_tag.bin;

    pvba_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (NUM_BINS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // bypass the write that lands in the same cycle as the read
    logic               r_fwd_hit;
    logic [PHASE_W-1:0] r_fwd_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= en && r_a_tag.valid && (r_a_tag.bin == c_tag.bin);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_phase <= r_a_phase;
    end

    logic [PHASE_W-1:0]      n_prev;
    logic [PHASE_W-1:0]      n_diff;
    logic [ADV_W-1:0]        n_adv;
    logic signed [TW-1:0]    n_t;
    logic signed [MPW-24:0]  n_mag_r;
    logic [MAG_W-1:0]        n_mag;

    always_comb begin
        if (r_a_tag.first) begin
            n_prev = '0;
        end else if (r_fwd_hit) begin
            n_prev = r_fwd_phase;
        end else begin
            n_prev = ram_rdata;
        end
        n_diff = r_a_phase - n_prev;
        n_adv  = (ADV_W'(r_a_tag.bin) * ADV_W'(r_hop)) << ADV_SHIFT;
        n_t    = TW'($signed(n_diff)) + $signed({2'b00, n_adv});

        n_mag_r = (MPW-23)'((r_a_magp + (MPW'(1) <<< 23)) >>> 24);
        if (n_mag_r[MPW-24]) begin
            n_mag = '0;
        end else if (n_mag_r[MPW-25:MAG_W] != '0) begin
            n_mag = '1;
        end else begin
            n_mag = n_mag_r[MAG_W-1:0];
        end
    end

    // stage B: phase advance and magnitude
    t_tag                 r_b_tag;
    logic signed [TW-1:0] r_b_t;
    logic [MAG_W-1:0]     r_b_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else if (en) begin
            r_b_tag <= r_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_t   <= n_t;
            r_b_mag <= n_mag;
        end
    end

    // stage C: scale by hertz per turn
    t_tag                 r_c_tag;
    logic signed [PW-1:0] r_c_prod;
    logic [MAG_W-1:0]     r_c_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag <= '0;
        end else if (en) begin
            r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_prod <= r_b_t * $signed({1'b0, r_gain});
            r_c_mag  <= r_b_mag;
        end
    end

    // output register: round, saturate
    logic signed [PW-17:0] n_f;
    logic signed [FREQ_W-1:0] n_freq;
    t_out_item r_out_item;

    always_comb begin
        n_f = (PW-16)'((r_c_prod + (PW'(1) <<< 15)) >>> 16);
        if (n_f > (PW-16)'(32'sh7FFF_FFFF)) begin
            n_freq = 32'sh7FFF_FFFF;
        end else if (n_f < -((PW-16)'(33'sh0_8000_0000))) begin
            n_freq = 32'sh8000_0000;
        end else begin
            n_freq = n_f[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.bin_out   <= r_c_tag.bin;
            r_out_item.magnitude <= r_c_mag;
            r_out_item.frequency <= n_freq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== verif/tb_phase_vocoder_bin_analysis_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_vocoder_bin_analysis_top
// Checks per-bin magnitude and frequency estimates against a CORDIC and
// phase-unwrap predictor, under random source gaps and sink stalls, across
// several hop and gain settings written over the APB port.
// ----------------------------------------------------------------------------
module tb_phase_vocoder_bin_analysis_top
    import pvba_pkg::*;
();

    localparam int LATENCY = CORDIC_STEPS + 4;
    localparam int STALL_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic [PHASE_W-1:0] prev_phase [NUM_BINS];
    logic [HOP_W-1:0]   hop_reg;
    logic [GAIN_W-1:0]  gain_reg;
    t_out_item          expected_q [$];

    int  n_errors = 0;
    int  n_results = 0;
    int  n_sent = 0;
    int  idle_cycles = 0;
    bit  sink_busy = 1'b1;  // 1: sink stalls randomly

    phase_vocoder_bin_analysis_top i_dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    // magnitude and phase of one bin, vectoring CORDIC
    task automatic cordic_polar(input longint re, input longint im,
                                output logic [15:0] ph, output logic [23:0] mag);
        longint x, y, dx, dy, m;
        logic [31:0] z;
        x = re * 256;
        y = im * 256;
        z = '0;
        if (re == 0 && im == 0) begin
            ph = '0;
            mag = '0;
            return;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += ATAN_TURNS[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ATAN_TURNS[i];
            end
        end
        z = z + 32'h8000;
        ph = z[31:16];
        m = floor_sh(x * 39797 + (longint'(1) << 23), 24);
        if (m < 0) m = 0;
        if (m > 24'hFFFFFF) m = 24'hFFFFFF;
        mag = m[23:0];
    endtask

    task automatic predict_bin(input t_in_item it);
        t_out_item   r;
        logic [15:0] ph, prv, diff;
        logic [23:0] mag;
        longint      d, t, f;
        cordic_polar(longint'(it.real_part), longint'(it.imag_part), ph, mag);
        prv = it.first_frame ? 16'd0 : prev_phase[it.bin_index];
        diff = ph - prv;
        d = diff[15] ? longint'(diff) - 65536 : longint'(diff);
        t = d + (longint'(it.bin_index) * hop_reg * 65536) / WINDOW_SIZE;
        f = floor_sh(t * longint'(gain_reg) + 32'h8000, 16);
        if (f > 64'sd2147483647) f = 64'sd2147483647;
        if (f < -64'sd2147483648) f = -64'sd2147483648;
        prev_phase[it.bin_index] = ph;
        r.bin_out = it.bin_index;
        r.magnitude = mag;
        r.frequency = f[31:0];
        expected_q.push_back(r);
    endtask

    // result checker and sink stalls
    always @(posedge i_clk) begin
        t_out_item e;
        if (o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", o_out_item);
            end else begin
                e = expected_q.pop_front();
                if (o_out_item.bin_out !== e.bin_out
                        || o_out_item.magnitude !== e.magnitude
                        || o_out_item.frequency !== e.frequency) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp bin %0d mag %0d freq %0d,",
                                  " got bin %0d mag %0d freq %0d"},
                                 e.bin_out, e.magnitude, e.frequency, o_out_item.bin_out,
                                 o_out_item.magnitude, o_out_item.frequency);
                end
            end
        end
    end

    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (sink_busy && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_bin(input t_in_item it, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        predict_bin(it);
        n_sent++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_HOP) hop_reg = val[HOP_W-1:0];
        else gain_reg = val[GAIN_W-1:0];
    endtask

    function automatic t_in_item rand_bin(logic [8:0] bin, bit first);
        t_in_item it;
        int k;
        k = $urandom_range(0, 7);
        it.real_part = 24'($urandom);
        it.imag_part = 24'($urandom);
        if (k == 0) it.real_part = it.real_part >>> $urandom_range(0, 23);
        if (k == 1) it.imag_part = it.imag_part >>> $urandom_range(0, 23);
        if (k == 2) it.real_part = '0;
        if (k == 3) it.imag_part = '0;
        it.bin_index = bin;
        it.first_frame = first;
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        logic signed [23:0] vals [5] = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1};
        foreach (vals[a]) begin
            foreach (vals[b]) begin
                if (b % 2 == a % 2) begin
                    it.real_part = vals[a];
                    it.imag_part = vals[b];
                    it.bin_index = (a * 5 + b) % 2 ? 9'd511 : 9'd0;
                    it.first_frame = (a == 0);
                    send_bin(it, 1'b0);
                end
            end
        end
        // half-turn difference: phase 0 then phase 1/2 turn on one bin
        it = '{24'sd1000, 24'sd0, 9'd7, 1'b1};
        send_bin(it, 1'b0);
        it = '{-24'sd1000, 24'sd0, 9'd7, 1'b0};
        send_bin(it, 1'b0);
        it = '{24'sd1000, 24'sd0, 9'd7, 1'b0};
        send_bin(it, 1'b0);
        // back-to-back same bin and high bins
        for (int i = 0; i < 4; i++) send_bin(rand_bin(9'd300, 1'b0), 1'b0);
        end_burst();
    endtask

    // frames of consecutive bins with random content, with random stray bins mixed in
    task automatic test_frames(input int n_items, input int max_bins);
        int nb, nf, base, done;
        done = 0;
        while (done < n_items) begin
            nb = $urandom_range(1, max_bins);
            nf = $urandom_range(1, 4);
            base = $urandom_range(0, 511);
            for (int f = 0; f < nf && done < n_items; f++) begin
                for (int b = 0; b < nb && done < n_items; b++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_bin(rand_bin(9'($urandom), 1'($urandom)), 1'b1);
                    else send_bin(rand_bin(9'((base + b) % 512), f == 0), 1'b1);
                    done++;
                end
            end
        end
        end_burst();
    endtask

    task automatic test_settings();
        logic [31:0] hops  [5] = '{32'd1, 32'd1024, 32'd0, 32'd2047, 32'd128};
        logic [31:0] gains [5] = '{32'd1, 32'hFFFFFF, 32'd0, 32'd11025, 32'h800000};
        for (int s = 0; s < 5; s++) begin
            apb_write(REG_HOP, hops[s]);
            apb_write(REG_GAIN, gains[s]);
            sink_busy = (s != 3);
            test_frames(300, 64);
        end
        apb_write(REG_HOP, $urandom_range(1, 1024));
        apb_write(REG_GAIN, $urandom_range(1, 24'hFFFFFF));
        sink_busy = 1'b1;
        test_frames(200, 512);
    endtask

    initial begin
        foreach (prev_phase[i]) prev_phase[i] = '0;
        hop_reg = HOP_RESET;
        gain_reg = GAIN_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_frames(100, 16);
        test_settings();
        $display("sent %0d bins, checked %0d results over six hop/gain settings",
                 n_sent, n_results);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
